// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is asserted
`define TFDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tfdc assertion failed");

// same, for a property that also holds through reset
`define TFDC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tfdc assertion failed");

`endif

// ===== src/tfdc_pkg.sv =====
`default_nettype none

package tfdc_pkg;

	localparam int MAX_PAYLOAD = 16;
	localparam int LEN_CAP     = (MAX_PAYLOAD < 16) ? MAX_PAYLOAD : 16;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = 5;
	localparam int POS_W       = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOOTER      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_CODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN  = 3'd5;

	localparam logic [7:0]       RST_HEADER      = 8'hAA;
	localparam logic [7:0]       RST_FOOTER      = 8'h55;
	localparam logic [7:0]       RST_FIRST_CODE  = 8'h02;
	localparam logic [CNT_W-1:0] RST_FIRST_LEN   = 5'd11;
	localparam logic [7:0]       RST_SECOND_CODE = 8'h03;
	localparam logic [CNT_W-1:0] RST_SECOND_LEN  = 5'd8;

	typedef struct packed {
		logic clr_sum;
		logic add_sum;
		logic load_type;
		logic load_len;
		logic store_pay;
		logic clr_idx;
		logic inc_idx;
		logic rd_en;
	} dp_cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic type_ok;
		logic len_ok;
		logic pay_done;
		logic sum_ok;
		logic ftr_ok;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== src/tfdc_in_if.sv =====
`default_nettype none

interface tfdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/tfdc_out_if.sv =====
`default_nettype none

interface tfdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_type;
	logic [7:0] payload_byte;
	logic [3:0] byte_position;
	logic       last_byte;

	modport source (output valid, output packet_type, output payload_byte,
		output byte_position, output last_byte, input ready);
	modport sink (input valid, input packet_type, input payload_byte,
		input byte_position, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== src/typed_frame_deframer_checksum.sv =====
// channel      dir   beat carries                                         handshake
// rx_chan      in    rx_byte                                              valid/ready
// result_chan  out   packet_type, payload_byte, byte_position, last_byte  valid/ready
// cfg          in    cfg_index, cfg_data                                  cfg_we, no wait
//
// each received byte is taken in one cycle while the frame is being parsed
// a good footer starts the payload burst: for each result beat the registered-read
// payload store is read first, and the beat is then presented until it is taken
// no bytes are taken until the last beat of the burst has gone
// arst_n returns the parser to header hunting and loads the register defaults
`default_nettype none

module typed_frame_deframer_checksum
	import tfdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tfdc_in_if.sink                    rx_chan,
	tfdc_out_if.source                 result_chan,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tfdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_chan.valid),
		.in_ready  (rx_chan.ready),
		.out_valid (result_chan.valid),
		.out_ready (result_chan.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tfdc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.rx_byte       (rx_chan.rx_byte),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.packet_type   (result_chan.packet_type),
		.payload_byte  (result_chan.payload_byte),
		.byte_position (result_chan.byte_position),
		.last_byte     (result_chan.last_byte)
	);

endmodule

`default_nettype wire

// ===== src/tfdc_ram.sv =====
`default_nettype none

module tfdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tfdc_dp.sv =====
`default_nettype none

module tfdc_dp
	import tfdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic      [7:0]            packet_type,
	output logic      [7:0]            payload_byte,
	output logic      [POS_W-1:0]      byte_position,
	output logic                       last_byte
);

	logic [7:0]       header_q;
	logic [7:0]       footer_q;
	logic [7:0]       code1_q;
	logic [CNT_W-1:0] len1_q;
	logic [7:0]       code2_q;
	logic [CNT_W-1:0] len2_q;

	logic [7:0]       type_q;
	logic [CNT_W-1:0] length_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic [POS_W-1:0] idx_q;

	logic [CNT_W-1:0] count_nxt;
	logic             len_match;
	logic             len_range;
	logic             ram_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= RST_HEADER;
			footer_q <= RST_FOOTER;
			code1_q  <= RST_FIRST_CODE;
			len1_q   <= RST_FIRST_LEN;
			code2_q  <= RST_SECOND_CODE;
			len2_q   <= RST_SECOND_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:      header_q <= cfg_data;
				REG_FOOTER:      footer_q <= cfg_data;
				REG_FIRST_CODE:  code1_q  <= cfg_data;
				REG_FIRST_LEN:   len1_q   <= cfg_data[CNT_W-1:0];
				REG_SECOND_CODE: code2_q  <= cfg_data;
				REG_SECOND_LEN:  len2_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= '0;
			length_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.load_type) begin
				type_q <= rx_byte;
			end
			if (cmd.clr_sum) begin
				sum_q <= '0;
			end else if (cmd.add_sum) begin
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.load_len) begin
				length_q <= rx_byte[CNT_W-1:0];
				count_q  <= '0;
			end else if (cmd.store_pay) begin
				count_q <= count_nxt;
			end
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign count_nxt = count_q + 1'b1;

	// either pairing of code and length will do when both codes are equal
	assign len_match = (type_q == code1_q && rx_byte == {3'b000, len1_q}) ||
		(type_q == code2_q && rx_byte == {3'b000, len2_q});
	assign len_range = (rx_byte != 8'd0) && (32'(rx_byte) <= LEN_CAP);

	assign stat.hdr_match = (rx_byte == header_q);
	assign stat.type_ok   = (rx_byte == code1_q) || (rx_byte == code2_q);
	assign stat.len_ok    = len_match && len_range;
	assign stat.pay_done  = (count_nxt >= length_q);
	assign stat.sum_ok    = (sum_q == rx_byte);
	assign stat.ftr_ok    = (rx_byte == footer_q);
	assign stat.last      = (({1'b0, idx_q} + 1'b1) == length_q);

	assign ram_we = cmd.store_pay && (32'(count_q) < MAX_PAYLOAD);

	tfdc_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(count_q)),
		.wdata (rx_byte),
		.re    (cmd.rd_en),
		.raddr (ADDR_W'(idx_q)),
		.rdata (payload_byte)
	);

	assign packet_type   = type_q;
	assign byte_position = idx_q;
	assign last_byte     = stat.last;

endmodule

`default_nettype wire

// ===== src/tfdc_ctrl.sv =====
`default_nettype none

module tfdc_ctrl
	import tfdc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	localparam logic [2:0] ST_HEADER  = 3'd0;
	localparam logic [2:0] ST_TYPE    = 3'd1;
	localparam logic [2:0] ST_LENGTH  = 3'd2;
	localparam logic [2:0] ST_PAYLOAD = 3'd3;
	localparam logic [2:0] ST_CHECK   = 3'd4;
	localparam logic [2:0] ST_FOOTER  = 3'd5;
	localparam logic [2:0] ST_RD      = 3'd6;
	localparam logic [2:0] ST_OUT     = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       acc;

	assign in_ready  = (state_q != ST_RD) && (state_q != ST_OUT);
	assign out_valid = (state_q == ST_OUT);
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_HEADER: begin
				if (acc && stat.hdr_match) begin
					cmd.clr_sum = 1'b1;
					state_nxt   = ST_TYPE;
				end
			end
			ST_TYPE: begin
				if (acc) begin
					cmd.load_type = 1'b1;
					if (stat.type_ok) begin
						cmd.add_sum = 1'b1;
						state_nxt   = ST_LENGTH;
					end else begin
						state_nxt = ST_HEADER;
					end
				end
			end
			ST_LENGTH: begin
				if (acc) begin
					if (stat.len_ok) begin
						cmd.load_len = 1'b1;
						cmd.add_sum  = 1'b1;
						state_nxt    = ST_PAYLOAD;
					end else begin
						state_nxt = ST_HEADER;
					end
				end
			end
			ST_PAYLOAD: begin
				if (acc) begin
					cmd.store_pay = 1'b1;
					cmd.add_sum   = 1'b1;
					if (stat.pay_done) begin
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (acc) begin
					state_nxt = stat.sum_ok ? ST_FOOTER : ST_HEADER;
				end
			end
			ST_FOOTER: begin
				if (acc) begin
					if (stat.ftr_ok) begin
						cmd.clr_idx = 1'b1;
						state_nxt   = ST_RD;
					end else begin
						state_nxt = ST_HEADER;
					end
				end
			end
			ST_RD: begin
				// store read is registered, data then held for the beat
				cmd.rd_en = 1'b1;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					if (stat.last) begin
						state_nxt = ST_HEADER;
					end else begin
						cmd.inc_idx = 1'b1;
						state_nxt   = ST_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/tfdc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module tfdc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] packet_type,
	input wire logic [7:0] payload_byte,
	input wire logic [3:0] byte_position,
	input wire logic       last_byte
);

	logic        out_fire;
	logic        stalled;
	logic        more;
	logic [20:0] beat_bits;
	logic [11:0] tag;
	logic [11:0] tag_next;

	assign out_fire  = out_valid && out_ready;
	assign stalled   = out_valid && !out_ready;
	assign more      = out_fire && !last_byte;
	assign beat_bits = {packet_type, payload_byte, byte_position, last_byte};
	assign tag       = {packet_type, byte_position};
	assign tag_next  = {packet_type, byte_position + 4'd1};

	// a stalled beat keeps its contents
	`TFDC_ASSERT(a_out_hold, clk, arst_n, stalled |=> (out_valid && $stable(beat_bits)))

	// input is closed while a burst is being delivered
	`TFDC_ASSERT(a_no_rx_in_burst, clk, arst_n, out_valid |-> !in_ready)

	// after a beat that is not the last, the burst goes on and input stays closed
	`TFDC_ASSERT(a_burst_continues, clk, arst_n, more |=> !in_ready)

	// next beat of a burst carries the next position and the same type
	`TFDC_ASSERT(a_pos_step, clk, arst_n, more |=> ##1 (out_valid && tag == $past(tag_next, 2)))

endmodule

bind typed_frame_deframer_checksum tfdc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (rx_chan.ready),
	.out_valid     (result_chan.valid),
	.out_ready     (result_chan.ready),
	.packet_type   (result_chan.packet_type),
	.payload_byte  (result_chan.payload_byte),
	.byte_position (result_chan.byte_position),
	.last_byte     (result_chan.last_byte)
);

`default_nettype wire
